// ===== src/tkh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_pkg
// shared widths, codes, types and helper functions of the top-k heap tracker
// ----------------------------------------------------------------------------
package tkh_pkg;

	localparam int HEAP_SLOTS = 32;
	localparam int IDX_W      = $clog2(HEAP_SLOTS);
	localparam int FILL_W     = $clog2(HEAP_SLOTS + 1);
	localparam int CHILD_W    = IDX_W + 2;

	localparam int CMD_W   = 2;
	localparam int KEY_W   = 32;
	localparam int CNT_W   = 63;
	localparam int TIME_W  = 32;
	localparam int SIDX_W  = 5;
	localparam int STAT_W  = 3;
	localparam int OCC_W   = 6;
	localparam int ENTRY_W = KEY_W + CNT_W + TIME_W;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 136;

	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(HEAP_SLOTS);

	// commands
	localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_REPLACED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_DELETED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;
	localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd6;
	localparam logic [STAT_W-1:0] ST_READ_OOR  = 3'd7;

	// read port a address select
	localparam logic [2:0] RA_SCAN   = 3'd0;
	localparam logic [2:0] RA_SIDX   = 3'd1;
	localparam logic [2:0] RA_LAST   = 3'd2;
	localparam logic [2:0] RA_ZERO   = 3'd3;
	localparam logic [2:0] RA_PARENT = 3'd4;
	localparam logic [2:0] RA_LEFT   = 3'd5;

	// index register update
	localparam logic [2:0] IDX_HOLD   = 3'd0;
	localparam logic [2:0] IDX_HIT    = 3'd1;
	localparam logic [2:0] IDX_FILL   = 3'd2;
	localparam logic [2:0] IDX_ZERO   = 3'd3;
	localparam logic [2:0] IDX_PARENT = 3'd4;
	localparam logic [2:0] IDX_CHILD  = 3'd5;

	// moving entry update
	localparam logic [1:0] CUR_HOLD = 2'd0;
	localparam logic [1:0] CUR_NEW  = 2'd1;
	localparam logic [1:0] CUR_RDA  = 2'd2;

	// fill level update
	localparam logic [1:0] FILL_HOLD = 2'd0;
	localparam logic [1:0] FILL_INC  = 2'd1;
	localparam logic [1:0] FILL_DEC  = 2'd2;

	// write data select
	localparam logic [1:0] WR_CUR    = 2'd0;
	localparam logic [1:0] WR_PARENT = 2'd1;
	localparam logic [1:0] WR_CHILD  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic              latch_in;
		logic              scan_clr;
		logic              scan_step;
		logic [2:0]        rd_a;
		logic [2:0]        idx_op;
		logic [1:0]        cur_op;
		logic [1:0]        fill_op;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic              res_set;
		logic [STAT_W-1:0] res_status;
		logic              res_evict;
		logic              res_read;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             hit;
		logic             scan_end;
		logic             full;
		logic             idx_last;
		logic             idx_zero;
		logic             par_less;
		logic             l_out;
		logic             dn_any;
		logic             replace_ok;
		logic             sidx_ok;
		logic             out_free;
	} dp_stat_t;

	function automatic logic [FILL_W-1:0] fill_of_idx(input logic [IDX_W-1:0] v);
		logic [IDX_W+FILL_W-1:0] w;
		w = '0;
		w[IDX_W-1:0] = v;
		return w[FILL_W-1:0];
	endfunction

	function automatic logic [CHILD_W-1:0] child_of_fill(input logic [FILL_W-1:0] v);
		logic [CHILD_W+FILL_W-1:0] w;
		w = '0;
		w[FILL_W-1:0] = v;
		return w[CHILD_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_of_sidx(input logic [SIDX_W-1:0] v);
		logic [IDX_W+SIDX_W-1:0] w;
		w = '0;
		w[SIDX_W-1:0] = v;
		return w[IDX_W-1:0];
	endfunction

	function automatic logic [FILL_W+SIDX_W-1:0] wide_of_sidx(input logic [SIDX_W-1:0] v);
		logic [FILL_W+SIDX_W-1:0] w;
		w = '0;
		w[SIDX_W-1:0] = v;
		return w;
	endfunction

	function automatic logic [FILL_W+SIDX_W-1:0] wide_of_fill(input logic [FILL_W-1:0] v);
		logic [FILL_W+SIDX_W-1:0] w;
		w = '0;
		w[FILL_W-1:0] = v;
		return w;
	endfunction

	function automatic logic [OCC_W-1:0] occ_of(input logic [FILL_W-1:0] v);
		logic [OCC_W+FILL_W-1:0] w;
		w = '0;
		w[FILL_W-1:0] = v;
		return w[OCC_W-1:0];
	endfunction

endpackage

// ===== src/tkh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tkh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/tkh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_dp
// heap datapath: slot ram, moving entry, index and fill registers, result regs
// ----------------------------------------------------------------------------
module tkh_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tkh_pkg::dp_cmd_t               ctl,
	output tkh_pkg::dp_stat_t              stat,
	input  logic [tkh_pkg::CMD_W-1:0]      in_cmd,
	input  logic [tkh_pkg::KEY_W-1:0]      in_key,
	input  logic [tkh_pkg::CNT_W-1:0]      in_count,
	input  logic [tkh_pkg::TIME_W-1:0]     in_time,
	input  logic [tkh_pkg::SIDX_W-1:0]     in_sidx,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tkh_pkg::STAT_W-1:0]     out_status,
	output logic [tkh_pkg::KEY_W-1:0]      out_key,
	output logic [tkh_pkg::CNT_W-1:0]      out_count,
	output logic [tkh_pkg::TIME_W-1:0]     out_time,
	output logic [tkh_pkg::OCC_W-1:0]      out_occ
);

	logic [tkh_pkg::CMD_W-1:0]  cmd_q;
	logic [tkh_pkg::KEY_W-1:0]  key_q;
	logic [tkh_pkg::CNT_W-1:0]  cnt_q;
	logic [tkh_pkg::TIME_W-1:0] now_q;
	logic [tkh_pkg::SIDX_W-1:0] sidx_q;
	logic [tkh_pkg::FILL_W-1:0] scan_q;
	logic [tkh_pkg::FILL_W-1:0] fill_q;
	logic [tkh_pkg::IDX_W-1:0]  idx_q;
	tkh_pkg::entry_t            cur_q;

	logic [tkh_pkg::STAT_W-1:0] res_status_q;
	logic [tkh_pkg::KEY_W-1:0]  res_key_q;
	logic [tkh_pkg::CNT_W-1:0]  res_cnt_q;
	logic [tkh_pkg::TIME_W-1:0] res_time_q;
	logic                       out_valid_q;

	tkh_pkg::entry_t            rd_a, rd_b, wdata, new_entry;
	logic [tkh_pkg::ENTRY_W-1:0] rdata_a, rdata_b;
	logic [tkh_pkg::IDX_W-1:0]  raddr_a, raddr_b, parent_idx, hit_idx, child_idx;
	logic [tkh_pkg::FILL_W:0]   scan1, scan2;
	logic [tkh_pkg::CHILD_W-1:0] lc, rc, fill_c;
	logic                       hit_a, hit_b, lv, rv, pick_b;
	logic [tkh_pkg::FILL_W-1:0] last_fill;

	assign rd_a = tkh_pkg::entry_t'(rdata_a);
	assign rd_b = tkh_pkg::entry_t'(rdata_b);
	assign new_entry = '{key: key_q, count: cnt_q, stamp: now_q};

	always_comb begin
		scan1      = {1'b0, scan_q} + 1'b1;
		scan2      = {1'b0, scan_q} + 2'd2;
		last_fill  = fill_q - 1'b1;
		parent_idx = (idx_q - 1'b1) >> 1;
		fill_c     = tkh_pkg::child_of_fill(fill_q);
		lc         = {2'b00, idx_q} + {2'b00, idx_q} + 1'b1;
		rc         = {2'b00, idx_q} + {2'b00, idx_q} + 2'd2;
		hit_a      = (scan_q < fill_q) && (rd_a.key == key_q);
		hit_b      = (scan1 < {1'b0, fill_q}) && (rd_b.key == key_q);
		hit_idx    = hit_a ? scan_q[tkh_pkg::IDX_W-1:0] : scan1[tkh_pkg::IDX_W-1:0];
		lv         = (lc < fill_c) && (rd_a.count < cur_q.count);
		rv         = rc < fill_c;
		pick_b     = rv && (rd_b.count < (lv ? rd_a.count : cur_q.count));
		child_idx  = pick_b ? rc[tkh_pkg::IDX_W-1:0] : lc[tkh_pkg::IDX_W-1:0];
	end

	always_comb begin
		raddr_a = scan_q[tkh_pkg::IDX_W-1:0];
		raddr_b = scan1[tkh_pkg::IDX_W-1:0];
		unique case (ctl.rd_a)
			tkh_pkg::RA_SCAN:   raddr_a = scan_q[tkh_pkg::IDX_W-1:0];
			tkh_pkg::RA_SIDX:   raddr_a = tkh_pkg::idx_of_sidx(sidx_q);
			tkh_pkg::RA_LAST:   raddr_a = last_fill[tkh_pkg::IDX_W-1:0];
			tkh_pkg::RA_ZERO:   raddr_a = '0;
			tkh_pkg::RA_PARENT: raddr_a = parent_idx;
			tkh_pkg::RA_LEFT: begin
				raddr_a = lc[tkh_pkg::IDX_W-1:0];
				raddr_b = rc[tkh_pkg::IDX_W-1:0];
			end
			default:            raddr_a = scan_q[tkh_pkg::IDX_W-1:0];
		endcase
	end

	always_comb begin
		unique case (ctl.wr_sel)
			tkh_pkg::WR_CUR:    wdata = cur_q;
			tkh_pkg::WR_PARENT: wdata = rd_a;
			tkh_pkg::WR_CHILD:  wdata = pick_b ? rd_b : rd_a;
			default:            wdata = cur_q;
		endcase
	end

	tkh_ram #(
		.WIDTH(tkh_pkg::ENTRY_W),
		.DEPTH(tkh_pkg::HEAP_SLOTS)
	) u_ram (
		.clk     (clk),
		.we      (ctl.wr_en),
		.waddr   (idx_q),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// status toward the controller
	always_comb begin
		stat.cmd        = cmd_q;
		stat.hit        = hit_a || hit_b;
		stat.scan_end   = scan2 >= {1'b0, fill_q};
		stat.full       = fill_q == tkh_pkg::FILL_MAX;
		stat.idx_last   = tkh_pkg::fill_of_idx(idx_q) == last_fill;
		stat.idx_zero   = idx_q == '0;
		stat.par_less   = cur_q.count < rd_a.count;
		stat.l_out      = lc >= fill_c;
		stat.dn_any     = lv || pick_b;
		stat.replace_ok = cnt_q > rd_a.count;
		stat.sidx_ok    = tkh_pkg::wide_of_sidx(sidx_q) < tkh_pkg::wide_of_fill(fill_q);
		stat.out_free   = !out_valid_q || out_ready;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q  <= in_cmd;
			key_q  <= in_key;
			cnt_q  <= in_count;
			now_q  <= in_time;
			sidx_q <= in_sidx;
		end
		if (ctl.scan_clr) begin
			scan_q <= '0;
		end else if (ctl.scan_step) begin
			scan_q <= scan2[tkh_pkg::FILL_W-1:0];
		end
		unique case (ctl.idx_op)
			tkh_pkg::IDX_HOLD:   idx_q <= idx_q;
			tkh_pkg::IDX_HIT:    idx_q <= hit_idx;
			tkh_pkg::IDX_FILL:   idx_q <= fill_q[tkh_pkg::IDX_W-1:0];
			tkh_pkg::IDX_ZERO:   idx_q <= '0;
			tkh_pkg::IDX_PARENT: idx_q <= parent_idx;
			tkh_pkg::IDX_CHILD:  idx_q <= child_idx;
			default:             idx_q <= idx_q;
		endcase
		unique case (ctl.cur_op)
			tkh_pkg::CUR_HOLD: cur_q <= cur_q;
			tkh_pkg::CUR_NEW:  cur_q <= new_entry;
			tkh_pkg::CUR_RDA:  cur_q <= rd_a;
			default:           cur_q <= cur_q;
		endcase
		if (ctl.res_set) begin
			res_status_q <= ctl.res_status;
			res_key_q    <= (ctl.res_evict || ctl.res_read) ? rd_a.key : '0;
			res_cnt_q    <= (ctl.res_evict || ctl.res_read) ? rd_a.count : '0;
			res_time_q   <= ctl.res_read ? rd_a.stamp : '0;
		end
		if (ctl.out_load) begin
			out_status <= res_status_q;
			out_key    <= res_key_q;
			out_count  <= res_cnt_q;
			out_time   <= res_time_q;
			out_occ    <= tkh_pkg::occ_of(fill_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (ctl.fill_op)
				tkh_pkg::FILL_HOLD: fill_q <= fill_q;
				tkh_pkg::FILL_INC:  fill_q <= fill_q + 1'b1;
				tkh_pkg::FILL_DEC:  fill_q <= last_fill;
				default:            fill_q <= fill_q;
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/tkh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_ctrl
// controller state machine: key scan, insert, delete, replace, read and sift steps
// ----------------------------------------------------------------------------
module tkh_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tkh_pkg::CMD_W-1:0] in_cmd,
	output logic                      in_ready,
	input  tkh_pkg::dp_stat_t         stat,
	output tkh_pkg::dp_cmd_t          ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_SCHK   = 4'd2;
	localparam logic [3:0] S_DEL    = 4'd3;
	localparam logic [3:0] S_DLOAD  = 4'd4;
	localparam logic [3:0] S_ROOT   = 4'd5;
	localparam logic [3:0] S_RD     = 4'd6;
	localparam logic [3:0] S_RDWAIT = 4'd7;
	localparam logic [3:0] S_UP     = 4'd8;
	localparam logic [3:0] S_UPCHK  = 4'd9;
	localparam logic [3:0] S_DOWN   = 4'd10;
	localparam logic [3:0] S_DNCHK  = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	logic [3:0] state_q, state_d;
	logic       first_q, first_d;

	always_comb begin
		state_d  = state_q;
		first_d  = first_q;
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					ctl.scan_clr = 1'b1;
					unique case (in_cmd)
						tkh_pkg::CMD_REPORT,
						tkh_pkg::CMD_DELETE: state_d = S_SCAN;
						tkh_pkg::CMD_READ:   state_d = S_RD;
						default: begin
							ctl.res_set    = 1'b1;
							ctl.res_status = tkh_pkg::ST_IGNORED;
							state_d        = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.rd_a = tkh_pkg::RA_SCAN;
				state_d  = S_SCHK;
			end
			S_SCHK: begin
				if (stat.hit) begin
					ctl.idx_op = tkh_pkg::IDX_HIT;
					if (stat.cmd == tkh_pkg::CMD_REPORT) begin
						ctl.cur_op     = tkh_pkg::CUR_NEW;
						ctl.res_set    = 1'b1;
						ctl.res_status = tkh_pkg::ST_UPDATED;
						first_d        = 1'b1;
						state_d        = S_UP;
					end else begin
						state_d = S_DEL;
					end
				end else if (stat.scan_end) begin
					if (stat.cmd == tkh_pkg::CMD_REPORT) begin
						if (!stat.full) begin
							ctl.idx_op     = tkh_pkg::IDX_FILL;
							ctl.fill_op    = tkh_pkg::FILL_INC;
							ctl.cur_op     = tkh_pkg::CUR_NEW;
							ctl.res_set    = 1'b1;
							ctl.res_status = tkh_pkg::ST_INSERTED;
							first_d        = 1'b1;
							state_d        = S_UP;
						end else begin
							ctl.rd_a = tkh_pkg::RA_ZERO;
							state_d  = S_ROOT;
						end
					end else begin
						ctl.res_set    = 1'b1;
						ctl.res_status = tkh_pkg::ST_NOT_FOUND;
						state_d        = S_DONE;
					end
				end else begin
					ctl.scan_step = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_DEL: begin
				ctl.fill_op    = tkh_pkg::FILL_DEC;
				ctl.res_set    = 1'b1;
				ctl.res_status = tkh_pkg::ST_DELETED;
				if (stat.idx_last) begin
					state_d = S_DONE;
				end else begin
					ctl.rd_a = tkh_pkg::RA_LAST;
					state_d  = S_DLOAD;
				end
			end
			S_DLOAD: begin
				ctl.cur_op = tkh_pkg::CUR_RDA;
				first_d    = 1'b1;
				state_d    = S_UP;
			end
			S_ROOT: begin
				ctl.res_set = 1'b1;
				if (stat.replace_ok) begin
					ctl.res_status = tkh_pkg::ST_REPLACED;
					ctl.res_evict  = 1'b1;
					ctl.cur_op     = tkh_pkg::CUR_NEW;
					ctl.idx_op     = tkh_pkg::IDX_ZERO;
					first_d        = 1'b1;
					state_d        = S_UP;
				end else begin
					ctl.res_status = tkh_pkg::ST_IGNORED;
					state_d        = S_DONE;
				end
			end
			S_RD: begin
				if (stat.sidx_ok) begin
					ctl.rd_a = tkh_pkg::RA_SIDX;
					state_d  = S_RDWAIT;
				end else begin
					ctl.res_set    = 1'b1;
					ctl.res_status = tkh_pkg::ST_READ_OOR;
					state_d        = S_DONE;
				end
			end
			S_RDWAIT: begin
				ctl.res_set    = 1'b1;
				ctl.res_status = tkh_pkg::ST_READ_OK;
				ctl.res_read   = 1'b1;
				state_d        = S_DONE;
			end
			S_UP: begin
				if (stat.idx_zero) begin
					if (first_q) begin
						state_d = S_DOWN;
					end else begin
						ctl.wr_en  = 1'b1;
						ctl.wr_sel = tkh_pkg::WR_CUR;
						state_d    = S_DONE;
					end
				end else begin
					ctl.rd_a = tkh_pkg::RA_PARENT;
					state_d  = S_UPCHK;
				end
			end
			S_UPCHK: begin
				if (stat.par_less) begin
					// parent moves down into the hole
					ctl.wr_en  = 1'b1;
					ctl.wr_sel = tkh_pkg::WR_PARENT;
					ctl.idx_op = tkh_pkg::IDX_PARENT;
					first_d    = 1'b0;
					state_d    = S_UP;
				end else if (first_q) begin
					state_d = S_DOWN;
				end else begin
					ctl.wr_en  = 1'b1;
					ctl.wr_sel = tkh_pkg::WR_CUR;
					state_d    = S_DONE;
				end
			end
			S_DOWN: begin
				if (stat.l_out) begin
					ctl.wr_en  = 1'b1;
					ctl.wr_sel = tkh_pkg::WR_CUR;
					state_d    = S_DONE;
				end else begin
					ctl.rd_a = tkh_pkg::RA_LEFT;
					state_d  = S_DNCHK;
				end
			end
			S_DNCHK: begin
				ctl.wr_en = 1'b1;
				if (stat.dn_any) begin
					// smaller child moves up into the hole
					ctl.wr_sel = tkh_pkg::WR_CHILD;
					ctl.idx_op = tkh_pkg::IDX_CHILD;
					state_d    = S_DOWN;
				end else begin
					ctl.wr_sel = tkh_pkg::WR_CUR;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

endmodule

// ===== src/top_k_min_heap_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_min_heap_tracker_top
// keeps the hottest keys in a count-ordered min-heap with key lookup
// ----------------------------------------------------------------------------
// channel  | direction | tuser    | tdata (lowest bit up)
// s_axis   | in        | cmd      | key_id, access_count, now_time, slot_index
// m_axis   | out       | status   | out_key, out_count, out_time, occupancy
//
// one transaction at a time; a read passes the read, wait and done states (no wait state when out of range)
// a report or delete takes the key scan (two slots per scan step over the two
// ram read ports) plus the control states plus a read and a check state per
// heap level sifted
// arst_n clears the fill level, the output valid and the controller; slot contents need no reset
// a new transaction is taken while the previous result still waits on m_axis
// ----------------------------------------------------------------------------
module top_k_min_heap_tracker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// key_id, access_count, now_time, slot_index, zero pad
	input  logic [tkh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// cmd
	input  logic [tkh_pkg::CMD_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_key, out_count, out_time, occupancy, zero pad
	output logic [tkh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// status
	output logic [tkh_pkg::STAT_W-1:0]         m_axis_tuser
);

	tkh_pkg::dp_cmd_t  ctl;
	tkh_pkg::dp_stat_t stat;

	logic [tkh_pkg::KEY_W-1:0]  o_key;
	logic [tkh_pkg::CNT_W-1:0]  o_cnt;
	logic [tkh_pkg::TIME_W-1:0] o_time;
	logic [tkh_pkg::OCC_W-1:0]  o_occ;

	// controller: steps through scan and sift
	tkh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: field slices of the input transaction
	tkh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_cmd     (s_axis_tuser),
		.in_key     (s_axis_tdata[31:0]),
		.in_count   (s_axis_tdata[94:32]),
		.in_time    (s_axis_tdata[126:95]),
		.in_sidx    (s_axis_tdata[131:127]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_key    (o_key),
		.out_count  (o_cnt),
		.out_time   (o_time),
		.out_occ    (o_occ)
	);

	// result packing, zero padded to whole bytes
	assign m_axis_tdata = {3'b000, o_occ, o_time, o_cnt, o_key};

endmodule
